[hdl/tadf_pkg.sv]
// Shared types and constants for the temperature average digit formatter.
`default_nettype none

package tadf_pkg;

	localparam int CODE_W  = 16;
	localparam int SUM_W   = 19;
	localparam int MILLI_W = 18;
	localparam int INT_W   = 9;
	localparam int FRAC_W  = 10;

	// floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every x below 493447
	localparam int RECIP_SHIFT = 28;
	localparam logic [18:0] RECIP_1000 = 19'd268436;

	localparam logic [4:0] TENS_MAX = 5'd9;

	typedef struct packed {
		logic               neg;
		logic [MILLI_W-1:0] milli;
	} scaled_t;

	typedef struct packed {
		logic              neg;
		logic [4:0]        tens;
		logic [3:0]        units;
		logic [FRAC_W-1:0] frac;
		logic              int_changed;
		logic              too_large;
	} int_split_t;

	typedef struct packed {
		logic       neg;
		logic [4:0] tens;
		logic [3:0] units;
		logic [3:0] tenths;
		logic [3:0] hundredths;
		logic [3:0] thousandths;
		logic       int_changed;
		logic       frac_changed;
		logic       too_large;
	} result_t;

endpackage

`default_nettype wire

[hdl/tadf_accum.sv]
// Sample history, five-sample sum and scaling to thousandths of a degree.
`default_nettype none

module tadf_accum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [15:0]          raw_code,
	output logic                        s1_valid,
	input  logic                        s1_ready,
	output tadf_pkg::scaled_t           s1_data
);

	logic signed [15:0]             hist_q [4];
	logic signed [tadf_pkg::SUM_W-1:0] sum;
	logic [tadf_pkg::SUM_W-1:0]     mag_full;
	logic [tadf_pkg::MILLI_W-1:0]   mag;
	logic [22:0]                    mag_ext;
	logic [22:0]                    mag_x25;
	logic                           take;
	logic                           valid_s1;
	tadf_pkg::scaled_t              data_s1;

	assign in_ready = !valid_s1 || s1_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		sum = 19'(raw_code) + 19'(hist_q[0]) + 19'(hist_q[1])
			+ 19'(hist_q[2]) + 19'(hist_q[3]);
		mag_full = sum[tadf_pkg::SUM_W-1] ? 19'(-sum) : 19'(sum);
		mag      = mag_full[tadf_pkg::MILLI_W-1:0];
		mag_ext  = {5'd0, mag};
		// times 25 as 16 + 8 + 1, then drop four bits for the divide by 16
		mag_x25  = (mag_ext << 4) + (mag_ext << 3) + mag_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				hist_q[i] <= '0;
			end
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				hist_q[3] <= hist_q[2];
				hist_q[2] <= hist_q[1];
				hist_q[1] <= hist_q[0];
				hist_q[0] <= raw_code;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1.neg   <= sum[tadf_pkg::SUM_W-1];
			data_s1.milli <= mag_x25[21:4];
		end
	end

	assign s1_valid = valid_s1;
	assign s1_data  = data_s1;

endmodule

`default_nettype wire

[hdl/tadf_int_split.sv]
// Split into integer degrees and thousandths remainder, track integer change.
`default_nettype none

module tadf_int_split (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s1_valid,
	output logic                 s1_ready,
	input  tadf_pkg::scaled_t    s1_data,
	output logic                 s3_valid,
	input  logic                 s3_ready,
	output tadf_pkg::int_split_t s3_data
);

	logic                           valid_s2;
	logic                           neg_s2;
	logic [tadf_pkg::MILLI_W-1:0]   milli_s2;
	logic [tadf_pkg::INT_W-1:0]     int_s2;
	logic                           valid_s3;
	tadf_pkg::int_split_t           data_s3;
	logic [tadf_pkg::INT_W-1:0]     last_int_q;

	logic [36:0]                    prod;
	logic                           ready_s3;
	logic                           move_s3;
	logic [tadf_pkg::MILLI_W-1:0]   int_x1000;
	logic [tadf_pkg::MILLI_W-1:0]   frac_full;
	logic [15:0]                    int_x205;
	logic [4:0]                     tens;
	logic [8:0]                     tens_x10;
	logic [8:0]                     units_full;

	assign ready_s3 = !valid_s3 || s3_ready;
	assign s1_ready = !valid_s2 || ready_s3;
	assign move_s3  = valid_s2 && ready_s3;

	assign prod = 37'(s1_data.milli) * 37'(tadf_pkg::RECIP_1000);

	always_comb begin
		int_x1000  = 18'(int_s2) * 18'd1000;
		frac_full  = milli_s2 - int_x1000;
		int_x205   = 16'(int_s2) * 16'd205;
		tens       = int_x205[15:11];
		tens_x10   = 9'(tens) * 9'd10;
		units_full = int_s2 - tens_x10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			last_int_q <= '0;
		end else begin
			if (s1_ready) begin
				valid_s2 <= s1_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (move_s3) begin
				last_int_q <= int_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_ready) begin
			neg_s2   <= s1_data.neg;
			milli_s2 <= s1_data.milli;
			int_s2   <= prod[36:28];
		end
		if (move_s3) begin
			data_s3.neg         <= neg_s2;
			data_s3.tens        <= tens;
			data_s3.units       <= units_full[3:0];
			data_s3.frac        <= frac_full[tadf_pkg::FRAC_W-1:0];
			data_s3.int_changed <= (int_s2 != last_int_q);
			data_s3.too_large   <= (tens > tadf_pkg::TENS_MAX);
		end
	end

	assign s3_valid = valid_s3;
	assign s3_data  = data_s3;

endmodule

`default_nettype wire

[hdl/tadf_frac_split.sv]
// Split the thousandths remainder into three digits, track fraction change.
`default_nettype none

module tadf_frac_split (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s3_valid,
	output logic                 s3_ready,
	input  tadf_pkg::int_split_t s3_data,
	output logic                 s4_valid,
	input  logic                 s4_ready,
	output tadf_pkg::result_t    s4_data
);

	logic                         valid_s4;
	tadf_pkg::result_t            data_s4;
	logic [tadf_pkg::FRAC_W-1:0]  last_frac_q;
	logic                         move_s4;
	logic [15:0]                  frac_x41;
	logic [3:0]                   tenths;
	logic [9:0]                   tenths_x100;
	logic [9:0]                   rem100_full;
	logic [6:0]                   rem100;
	logic [14:0]                  rem_x205;
	logic [3:0]                   hund;
	logic [6:0]                   hund_x10;
	logic [6:0]                   thou_full;

	assign s3_ready = !valid_s4 || s4_ready;
	assign move_s4  = s3_valid && s3_ready;

	always_comb begin
		frac_x41    = 16'(s3_data.frac) * 16'd41;
		tenths      = frac_x41[15:12];
		tenths_x100 = 10'(tenths) * 10'd100;
		rem100_full = s3_data.frac - tenths_x100;
		rem100      = rem100_full[6:0];
		rem_x205    = 15'(rem100) * 15'd205;
		hund        = rem_x205[14:11];
		hund_x10    = 7'(hund) * 7'd10;
		thou_full   = rem100 - hund_x10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4    <= 1'b0;
			last_frac_q <= '0;
		end else begin
			if (s3_ready) begin
				valid_s4 <= s3_valid;
			end
			if (move_s4) begin
				last_frac_q <= s3_data.frac;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s4) begin
			data_s4.neg          <= s3_data.neg;
			data_s4.tens         <= s3_data.tens;
			data_s4.units        <= s3_data.units;
			data_s4.tenths       <= tenths;
			data_s4.hundredths   <= hund;
			data_s4.thousandths  <= thou_full[3:0];
			data_s4.int_changed  <= s3_data.int_changed;
			data_s4.frac_changed <= (s3_data.frac != last_frac_q);
			data_s4.too_large    <= s3_data.too_large;
		end
	end

	assign s4_valid = valid_s4;
	assign s4_data  = data_s4;

endmodule

`default_nettype wire

[hdl/temp_average_digit_formatter_top.sv]
// Top level: five-sample temperature average split into display digits.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid / in_ready | raw_code (signed 16b, 1/128 degree)
//   output  | out_valid/out_ready | is_negative, tens..thousandths digits,
//           |                     | integer_changed, fraction_changed, too_large
//
// Four register stages: sum and scale, divide by 1000, integer digits,
// fraction digits. One request is taken every cycle while the output is not
// stalled; out_valid rises once a taken request has passed stages two to four.
// Each stage holds while the one after it is full and stalled, so bubbles
// collapse and in_ready drops only when all four stages are full.
// Reset clears the history, the previous integer and fraction parts and all valid bits.
`default_nettype none

module temp_average_digit_formatter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] raw_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               is_negative,
	output logic [4:0]         tens_digit,
	output logic [3:0]         units_digit,
	output logic [3:0]         tenths_digit,
	output logic [3:0]         hundredths_digit,
	output logic [3:0]         thousandths_digit,
	output logic               integer_changed,
	output logic               fraction_changed,
	output logic               too_large
);

	logic                 s1_valid;
	logic                 s1_ready;
	tadf_pkg::scaled_t    s1_data;
	logic                 s3_valid;
	logic                 s3_ready;
	tadf_pkg::int_split_t s3_data;
	tadf_pkg::result_t    res;

	// advance the sample history and form the scaled magnitude
	tadf_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.raw_code (raw_code),
		.s1_valid (s1_valid),
		.s1_ready (s1_ready),
		.s1_data  (s1_data)
	);

	// whole degrees, their two digits and the change against the last request
	tadf_int_split u_int_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1_ready (s1_ready),
		.s1_data  (s1_data),
		.s3_valid (s3_valid),
		.s3_ready (s3_ready),
		.s3_data  (s3_data)
	);

	// fraction digits; the final stage doubles as the output register
	tadf_frac_split u_frac_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.s3_valid (s3_valid),
		.s3_ready (s3_ready),
		.s3_data  (s3_data),
		.s4_valid (out_valid),
		.s4_ready (out_ready),
		.s4_data  (res)
	);

	assign is_negative       = res.neg;
	assign tens_digit        = res.tens;
	assign units_digit       = res.units;
	assign tenths_digit      = res.tenths;
	assign hundredths_digit  = res.hundredths;
	assign thousandths_digit = res.thousandths;
	assign integer_changed   = res.int_changed;
	assign fraction_changed  = res.frac_changed;
	assign too_large         = res.too_large;

endmodule

`default_nettype wire

[test/tb_temp_average_digit_formatter_top.sv]
// Self-checking testbench for the five-sample temperature average digit formatter.
module tb_temp_average_digit_formatter_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Request and result channels of the block
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] raw_code;
	logic               out_valid;
	logic               out_ready;
	logic               is_negative;
	logic [4:0]         tens_digit;
	logic [3:0]         units_digit;
	logic [3:0]         tenths_digit;
	logic [3:0]         hundredths_digit;
	logic [3:0]         thousandths_digit;
	logic               integer_changed;
	logic               fraction_changed;
	logic               too_large;

	// Shadow state of the averager: last four codes (newest first) and the
	// magnitude parts of the previous reading, used for the change flags
	logic signed [15:0]          shadow_codes [4];
	logic [tadf_pkg::INT_W-1:0]  shadow_int;
	logic [tadf_pkg::FRAC_W-1:0] shadow_frac;

	// Readings predicted for accepted requests, oldest first
	tadf_pkg::result_t pending_readings [$];

	int  fail_count;
	int  reported;
	bit  no_idle;
	int  stall_left;

	temp_average_digit_formatter_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.raw_code         (raw_code),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.is_negative      (is_negative),
		.tens_digit       (tens_digit),
		.units_digit      (units_digit),
		.tenths_digit     (tenths_digit),
		.hundredths_digit (hundredths_digit),
		.thousandths_digit(thousandths_digit),
		.integer_changed  (integer_changed),
		.fraction_changed (fraction_changed),
		.too_large        (too_large)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous fixed limit: far above the slowest legal run with every
	// request and result waiting out the longest gap
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 30);
	endfunction

	// Fold one code into the shadow average and produce the reading it yields.
	// Magnitude in thousandths: floor(|sum| * 1000 / (5 * 128)) = floor(|sum| * 25 / 16)
	task automatic advance_average(input logic signed [15:0] code,
		output tadf_pkg::result_t reading);
		int sum;
		int mag;
		int milli;
		int int_part;
		int frac_part;
		sum = code;
		for (int i = 0; i < 4; i++)
			sum += shadow_codes[i];
		for (int i = 3; i > 0; i--)
			shadow_codes[i] = shadow_codes[i-1];
		shadow_codes[0] = code;

		mag   = (sum < 0) ? -sum : sum;
		milli = (mag * 25) / 16;

		reading.neg          = (sum < 0);
		reading.tens         = 5'(milli / 10000);
		reading.units        = 4'((milli / 1000) % 10);
		reading.tenths       = 4'((milli / 100) % 10);
		reading.hundredths   = 4'((milli / 10) % 10);
		reading.thousandths  = 4'(milli % 10);

		// Sign plays no part in either change flag
		int_part  = milli / 1000;
		frac_part = milli % 1000;
		reading.int_changed  = (tadf_pkg::INT_W'(int_part) != shadow_int);
		reading.frac_changed = (tadf_pkg::FRAC_W'(frac_part) != shadow_frac);
		reading.too_large    = (reading.tens > tadf_pkg::TENS_MAX);

		shadow_int  = tadf_pkg::INT_W'(int_part);
		shadow_frac = tadf_pkg::FRAC_W'(frac_part);
	endtask

	// Present one request, hold it until taken, then record its reading.
	// in_valid is lowered only when a gap follows, so a back-to-back request
	// never sees a low and a high assignment in the same step.
	task automatic send_code(input logic signed [15:0] code);
		int                gap;
		tadf_pkg::result_t reading;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_code <= code;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		advance_average(code, reading);
		pending_readings.push_back(reading);
	endtask

	// Clamp a wide value into the code range
	function automatic logic signed [15:0] clamp_code(input int v);
		if (v > 32767)
			return 16'sh7fff;
		else if (v < -32768)
			return 16'sh8000;
		else
			return 16'(v);
	endfunction

	// Sink side: drop out_ready for random stretches, hold it high otherwise
	initial begin
		out_ready  <= 1'b0;
		stall_left  = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Compare every taken result with the oldest predicted reading
	always @(posedge clk) begin
		tadf_pkg::result_t got;
		tadf_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{is_negative, tens_digit, units_digit, tenths_digit,
				hundredths_digit, thousandths_digit, integer_changed,
				fraction_changed, too_large};
			if (pending_readings.size() == 0) begin
				fail_count++;
				if (reported < 10) begin
					reported++;
					$display({"unexpected result: neg %0d digits %0d %0d.%0d%0d%0d",
						" chg %0d%0d big %0d"},
						got.neg, got.tens, got.units, got.tenths, got.hundredths,
						got.thousandths, got.int_changed, got.frac_changed, got.too_large);
				end
			end else begin
				want = pending_readings.pop_front();
				if (got !== want) begin
					fail_count++;
					if (reported < 10) begin
						reported++;
						$display({"mismatch expected: neg %0d digits %0d %0d.%0d%0d%0d",
							" chg %0d%0d big %0d"},
							want.neg, want.tens, want.units, want.tenths, want.hundredths,
							want.thousandths, want.int_changed, want.frac_changed,
							want.too_large);
						$display({"         actual:   neg %0d digits %0d %0d.%0d%0d%0d",
							" chg %0d%0d big %0d"},
							got.neg, got.tens, got.units, got.tenths, got.hundredths,
							got.thousandths, got.int_changed, got.frac_changed,
							got.too_large);
					end
				end
			end
		end
	end

	// Extremes, the zero history after reset, smallest magnitudes and a
	// change of sign with an unchanged magnitude
	task automatic test_directed();
		// First request averages against the cleared history
		send_code(16'sd0);
		// Full-scale positive: tens digit far beyond 9
		repeat (5) send_code(16'sh7fff);
		repeat (4) send_code(16'sd0);
		// Full-scale negative: largest magnitude of all
		repeat (5) send_code(16'sh8000);
		repeat (5) send_code(16'sd0);
		// Smallest positive sum, then a sum of -1: sign flips, flags stay low
		send_code(16'sd1);
		send_code(-16'sd2);
		// Just below and then exactly at the 100 degree display limit
		repeat (4) send_code(16'sd12800);
		send_code(16'sd12799);
		send_code(16'sd12801);
		// Alternating bit patterns
		send_code(16'sh5555);
		send_code(16'shaaaa);
	endtask

	// Codes drawn over the whole range
	task automatic test_random_codes(input int count);
		logic [31:0] r;
		for (int i = 0; i < count; i++) begin
			r = $urandom;
			send_code(r[15:0]);
		end
	endtask

	// Runs of nearly equal codes, so the average settles and the change
	// flags and digit carries are exercised around each level
	task automatic test_steady_runs(input int count);
		int sent;
		int base;
		int run_len;
		logic [31:0] r;
		sent = 0;
		while (sent < count) begin
			r = $urandom;
			case ($urandom_range(0, 3))
				0: base = $signed(r[15:0]);
				1: base = (r[16] ? -12800 : 12800) + $signed(r[7:0]);
				2: base = $urandom_range(0, 1000) - 500;
				default: base = r[16] ? 32767 - r[5:0] : -32768 + r[5:0];
			endcase
			run_len = $urandom_range(3, 10);
			for (int k = 0; k < run_len; k++) begin
				send_code(clamp_code(base + $urandom_range(0, 4) - 2));
				sent++;
			end
		end
	endtask

	// Both sides without idling: one request and one result every cycle
	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		test_random_codes(count);
		no_idle = 1'b0;
	endtask

	initial begin
		fail_count = 0;
		reported   = 0;
		no_idle    = 1'b0;
		for (int i = 0; i < 4; i++)
			shadow_codes[i] = '0;
		shadow_int  = '0;
		shadow_frac = '0;

		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		raw_code <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_codes(250);
		test_steady_runs(380);
		test_back_to_back(100);

		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		// Let any stray result surface through the four stages
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
